// ----- rtl/wwdt_pkg.sv -----
// wwdt_pkg: shared types and constants for the windowed watchdog timer
// request and response payload structs, mode codes and default register map
// no dependencies
`default_nettype none

package wwdt_pkg;

   localparam int ADDR_W   = 16;
   localparam int DATA_W   = 8;
   localparam int CYCLES_W = 32;
   localparam int BASE_W   = 17;
   localparam int NIB_W    = 4;

   localparam logic [ADDR_W-1:0] DEFAULT_CTRL_ADDR    = 16'h0100;
   localparam logic [ADDR_W-1:0] DEFAULT_WINCTRL_ADDR = 16'h0101;
   localparam logic [ADDR_W-1:0] DEFAULT_INTCTRL_ADDR = 16'h0102;
   localparam logic [ADDR_W-1:0] DEFAULT_STATUS_ADDR  = 16'h0103;
   localparam logic [BASE_W-1:0] DEFAULT_BASE_PERIOD_CYCLES = 17'd128000;

   // bit positions inside the interrupt enable and status registers
   localparam int EWIE_BIT = 0;
   localparam int EWIF_BIT = 0;

   typedef enum logic [1:0] {
      MODE_TICK    = 2'd0,
      MODE_READ    = 2'd1,
      MODE_WRITE   = 2'd2,
      MODE_RESTART = 2'd3
   } wwdt_mode_type;

   typedef struct packed {
      wwdt_mode_type         mode;
      logic [ADDR_W-1:0]     address;
      logic [DATA_W-1:0]     write_data;
      logic [CYCLES_W-1:0]   tick_cycles;
   } wwdt_req_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              watchdog_reset;
      logic              interrupt_pending;
   } wwdt_rsp_type;

endpackage

`default_nettype wire

// ----- rtl/windowed_watchdog_timer_top.sv -----
// windowed_watchdog_timer_top: windowed watchdog with early warning flag
// four byte registers on a small bus, tick and restart requests
// depends on wwdt_pkg
`default_nettype none

// One request is taken per clock while the response side keeps taking results.
// The request is captured in an input register, and when the response register
// can advance a single pass of logic (a 32-bit saturating add, the half/full
// timeout compares and the register decode) updates the watchdog state and
// loads the response register, from which the response is presented. The
// sustained rate is one request per cycle while the response side keeps taking
// results; that add-and-compare chain sets the clock.
// Reaching the timeout, or a restart while the window is still closed,
// sets watchdog_reset in that response and returns all watchdog state registers to zero.
module windowed_watchdog_timer_top #(
   parameter logic [wwdt_pkg::ADDR_W-1:0] CTRL_ADDR    = wwdt_pkg::DEFAULT_CTRL_ADDR,
   parameter logic [wwdt_pkg::ADDR_W-1:0] WINCTRL_ADDR = wwdt_pkg::DEFAULT_WINCTRL_ADDR,
   parameter logic [wwdt_pkg::ADDR_W-1:0] INTCTRL_ADDR = wwdt_pkg::DEFAULT_INTCTRL_ADDR,
   parameter logic [wwdt_pkg::ADDR_W-1:0] STATUS_ADDR  = wwdt_pkg::DEFAULT_STATUS_ADDR,
   parameter logic [wwdt_pkg::BASE_W-1:0] BASE_PERIOD_CYCLES =
      wwdt_pkg::DEFAULT_BASE_PERIOD_CYCLES
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire wwdt_pkg::wwdt_req_type req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output wwdt_pkg::wwdt_rsp_type      rsp_data
);

   import wwdt_pkg::*;

   localparam logic [CYCLES_W-1:0] BASE32 = CYCLES_W'(BASE_PERIOD_CYCLES);

   // input stage
   logic         req_valid_ff;
   wwdt_req_type req_ff;
   // output stage
   logic         rsp_valid_ff;
   wwdt_rsp_type rsp_ff;
   logic         rsp_valid_in;
   wwdt_rsp_type rsp_in;

   // watchdog state
   logic [DATA_W-1:0]   ctrl_ff, ctrl_in;
   logic [DATA_W-1:0]   winctrl_ff, winctrl_in;
   logic [DATA_W-1:0]   intctrl_ff, intctrl_in;
   logic [DATA_W-1:0]   status_ff, status_in;
   logic                running_ff, running_in;
   logic [CYCLES_W-1:0] elapsed_ff, elapsed_in;
   logic [CYCLES_W-1:0] timeout_ff, timeout_in;
   logic [CYCLES_W-1:0] window_ff, window_in;

   logic advance;
   logic process;

   logic hit_ctrl, hit_win, hit_int, hit_stat;
   logic [DATA_W-1:0]   new_ctrl, new_win;
   logic [NIB_W-1:0]    new_period, new_win_nib, cur_win_nib;
   logic [CYCLES_W:0]   sum_wide;
   logic [CYCLES_W-1:0] sum_sat, half;
   logic                fired;
   logic [DATA_W-1:0]   rdata;

   function automatic logic [CYCLES_W-1:0] scaled_limit(input logic [NIB_W-1:0] nib);
      logic [NIB_W-1:0] sh;
      sh = nib - NIB_W'(1);
      return BASE32 << sh;
   endfunction

   function automatic logic [NIB_W-1:0] window_nibble(input logic [DATA_W-1:0] ctrl,
                                                      input logic [DATA_W-1:0] win);
      // a zero window address takes the window from the control high nibble
      if (WINCTRL_ADDR != '0) begin
         return win[NIB_W-1:0];
      end
      return ctrl[DATA_W-1:NIB_W];
   endfunction

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign process   = req_valid_ff && advance;
   assign req_ready = !req_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      hit_ctrl = (req_ff.address == CTRL_ADDR);
      hit_win  = !hit_ctrl && (req_ff.address == WINCTRL_ADDR);
      hit_int  = !hit_ctrl && !hit_win && (req_ff.address == INTCTRL_ADDR);
      hit_stat = !hit_ctrl && !hit_win && !hit_int && (req_ff.address == STATUS_ADDR);

      new_ctrl    = hit_ctrl ? req_ff.write_data : ctrl_ff;
      new_win     = hit_win ? req_ff.write_data : winctrl_ff;
      new_period  = new_ctrl[NIB_W-1:0];
      new_win_nib = window_nibble(new_ctrl, new_win);
      cur_win_nib = window_nibble(ctrl_ff, winctrl_ff);

      sum_wide = {1'b0, elapsed_ff} + {1'b0, req_ff.tick_cycles};
      sum_sat  = sum_wide[CYCLES_W] ? '1 : sum_wide[CYCLES_W-1:0];
      half     = timeout_ff >> 1;

      ctrl_in    = ctrl_ff;
      winctrl_in = winctrl_ff;
      intctrl_in = intctrl_ff;
      status_in  = status_ff;
      running_in = running_ff;
      elapsed_in = elapsed_ff;
      timeout_in = timeout_ff;
      window_in  = window_ff;
      fired      = 1'b0;
      rdata      = '0;

      if (process) begin
         unique case (req_ff.mode)
            MODE_TICK: begin
               if (running_ff) begin
                  elapsed_in = sum_sat;
                  if (elapsed_ff < half && sum_sat >= half) begin
                     status_in[EWIF_BIT] = 1'b1;
                  end
                  if (sum_sat >= timeout_ff) begin
                     fired = 1'b1;
                  end
               end
            end
            MODE_READ: begin
               priority if (hit_ctrl) begin
                  rdata = ctrl_ff;
               end else if (hit_win) begin
                  rdata = winctrl_ff;
               end else if (hit_int) begin
                  rdata = intctrl_ff;
               end else if (hit_stat) begin
                  rdata = status_ff;
               end else begin
                  rdata = '0;
               end
            end
            MODE_WRITE: begin
               if (hit_ctrl || hit_win) begin
                  ctrl_in    = new_ctrl;
                  winctrl_in = new_win;
                  // a zero period stops the timer and keeps the old limits
                  if (new_period != '0) begin
                     running_in = 1'b1;
                     timeout_in = scaled_limit(new_period);
                     window_in  = (new_win_nib != '0) ? scaled_limit(new_win_nib) : '0;
                  end else begin
                     running_in = 1'b0;
                  end
               end else if (hit_int) begin
                  intctrl_in = req_ff.write_data;
               end else if (hit_stat && req_ff.write_data[EWIF_BIT]) begin
                  status_in[EWIF_BIT] = 1'b0;
               end
            end
            MODE_RESTART: begin
               // restart inside the closed window is a violation
               if (running_ff && cur_win_nib != '0 && elapsed_ff < window_ff) begin
                  fired = 1'b1;
               end else begin
                  elapsed_in = '0;
               end
            end
            default: begin
            end
         endcase

         if (fired) begin
            ctrl_in    = '0;
            winctrl_in = '0;
            intctrl_in = '0;
            status_in  = '0;
            running_in = 1'b0;
            elapsed_in = '0;
            timeout_in = '0;
            window_in  = '0;
         end
      end

      rsp_in.read_data         = rdata;
      rsp_in.watchdog_reset    = fired;
      rsp_in.interrupt_pending = intctrl_in[EWIE_BIT] && status_in[EWIF_BIT];

      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ctrl_ff      <= '0;
         winctrl_ff   <= '0;
         intctrl_ff   <= '0;
         status_ff    <= '0;
         running_ff   <= 1'b0;
         elapsed_ff   <= '0;
         timeout_ff   <= '0;
         window_ff    <= '0;
      end else begin
         if (req_ready) begin
            req_valid_ff <= req_valid;
         end
         rsp_valid_ff <= rsp_valid_in;
         ctrl_ff      <= ctrl_in;
         winctrl_ff   <= winctrl_in;
         intctrl_ff   <= intctrl_in;
         status_ff    <= status_in;
         running_ff   <= running_in;
         elapsed_ff   <= elapsed_in;
         timeout_ff   <= timeout_in;
         window_ff    <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         req_ff <= req_data;
      end
      if (process) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire
